@@ rtl/core/i2cms_pkg.sv @@
// Package for the I2C master transaction sequencer: phase, command and
// register codes, and the input and result record types.
// No dependencies; imported by i2c_master_transaction_sequencer_unit.
`default_nettype none

package i2cms_pkg;

    // Longest transfer in bytes; the byte count saturates here.
    localparam int MAX_LENGTH = 255;
    localparam logic [7:0] LEN_MAX = 8'((MAX_LENGTH > 255) ? 255 : MAX_LENGTH);

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_TX       = 5'd3,
        PH_RX       = 5'd4,
        PH_TX_EMPTY = 5'd5,
        PH_RESTART  = 5'd8,
        PH_RESET    = 5'd14
    } t_phase;

    typedef enum logic [1:0] {
        ACT_START_WRITE = 2'd0,
        ACT_START_READ  = 2'd1,
        ACT_EVENT       = 2'd2,
        ACT_OPEN        = 2'd3
    } t_action;

    // Follow-up actions held in the action registers.
    localparam logic [1:0] FOLLOW_STOP     = 2'd0;
    localparam logic [1:0] FOLLOW_RESTART_RD = 2'd1;
    localparam logic [1:0] FOLLOW_RESTART_WR = 2'd2;
    localparam logic [1:0] FOLLOW_CONTINUE = 2'd3;

    // Controller commands.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_RECV  = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    // Acknowledge settings for received bytes.
    localparam logic [1:0] ACK_KEEP = 2'd0;
    localparam logic [1:0] ACK_SET  = 2'd1;
    localparam logic [1:0] ACK_NACK = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_TARGET_ADDRESS   = 3'd0;
    localparam logic [2:0] REG_TRANSFER_LENGTH  = 3'd1;
    localparam logic [2:0] REG_ON_DATA_COMPLETE = 3'd2;
    localparam logic [2:0] REG_ON_DATA_NACK     = 3'd3;
    localparam logic [2:0] REG_ON_ADDRESS_NACK  = 3'd4;
    localparam logic [2:0] REG_ON_COLLISION     = 3'd5;

    typedef struct packed {
        t_action    action;
        logic       nack_seen;
        logic       arbitration_lost;
        logic       bus_error;
        logic [7:0] received_byte;
        logic [7:0] next_tx_byte;
    } t_item;

    typedef struct packed {
        logic       accepted;
        logic       addr_valid;
        logic [7:0] addr_byte;
        logic       data_valid;
        logic [7:0] data_byte;
        logic [1:0] ack_action;
        logic [1:0] bus_command;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       busy_res;
        logic       failed;
        logic       buffer_done;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/i2c_master_transaction_sequencer_unit.sv @@
// Top level of the I2C master transaction sequencer: input register,
// single-pass phase logic and result register. Depends on i2cms_pkg.
`default_nettype none

// Channel   | Direction | Handshake                    | Contents
// ----------+-----------+------------------------------+--------------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | command or controller event
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | controller commands and status
// cfg       | in        | i_cfg_valid/o_cfg_ready      | register index and write data
//
// Every transaction on s_axis yields exactly one result on m_axis. A new
// transaction can be taken every cycle while m_axis is not stalled; each
// passes through the input register and then the result register, with a
// single phase update between them. Reset is synchronous and active low:
// it puts the sequencer in its reset phase with the counters and flags
// cleared and the registers at their defaults. A stall on m_axis holds the
// result and, once the input register is also full, drops s_axis_tready;
// configuration writes are taken only while the input register is empty.

module i2c_master_transaction_sequencer_unit
    import i2cms_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata, lowest bit up: nack_seen, arbitration_lost, bus_error,
    // received_byte[7:0], next_tx_byte[7:0], five zero bits
    input  wire logic [23:0] s_axis_tdata,
    // tuser: action[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata, lowest bit up: accepted, addr_valid, addr_byte[7:0], data_valid,
    // data_byte[7:0], ack_action[1:0], bus_command[1:0], rx_valid,
    // rx_data[7:0], busy_res, failed, buffer_done, five zero bits
    output logic [39:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    // Pipeline registers.
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;

    // Configuration registers.
    logic [6:0] r_target_address;
    logic [7:0] r_transfer_length;
    logic [1:0] r_on_data_complete, n_on_data_complete;
    logic [1:0] r_on_data_nack, n_on_data_nack;
    logic [1:0] r_on_address_nack, n_on_address_nack;
    logic [1:0] r_on_collision, n_on_collision;

    // Transfer state.
    t_phase     r_phase, n_phase;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic       r_watch_addr, n_watch_addr;
    logic       r_busy, n_busy;
    logic       r_error, n_error;
    t_result    n_out;

    // The phase logic runs when the input register is full and the result
    // register is empty or being emptied in this cycle.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign o_cfg_ready   = !r_in_valid;

    assign m_axis_tdata = {5'b0, r_out.buffer_done, r_out.failed, r_out.busy_res,
                           r_out.rx_data, r_out.rx_valid, r_out.bus_command,
                           r_out.ack_action, r_out.data_byte, r_out.data_valid,
                           r_out.addr_byte, r_out.addr_valid, r_out.accepted};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.action           <= t_action'(s_axis_tuser);
            r_in.nack_seen        <= s_axis_tdata[0];
            r_in.arbitration_lost <= s_axis_tdata[1];
            r_in.bus_error        <= s_axis_tdata[2];
            r_in.received_byte    <= s_axis_tdata[10:3];
            r_in.next_tx_byte     <= s_axis_tdata[18:11];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Transfer state and registers. Configuration is only taken while the
    // input register is empty, so a write never meets a step in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= PH_RESET;
            r_bytes_left       <= 8'd0;
            r_watch_addr       <= 1'b0;
            r_busy             <= 1'b0;
            r_error            <= 1'b0;
            r_target_address   <= 7'd0;
            r_transfer_length  <= 8'd1;
            r_on_data_complete <= FOLLOW_STOP;
            r_on_data_nack     <= FOLLOW_STOP;
            r_on_address_nack  <= FOLLOW_STOP;
            r_on_collision     <= FOLLOW_STOP;
        end else if (advance) begin
            r_phase            <= n_phase;
            r_bytes_left       <= n_bytes_left;
            r_watch_addr       <= n_watch_addr;
            r_busy             <= n_busy;
            r_error            <= n_error;
            r_on_data_complete <= n_on_data_complete;
            r_on_data_nack     <= n_on_data_nack;
            r_on_address_nack  <= n_on_address_nack;
            r_on_collision     <= n_on_collision;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TARGET_ADDRESS:   r_target_address   <= i_cfg_data[6:0];
                REG_TRANSFER_LENGTH:  r_transfer_length  <= i_cfg_data;
                REG_ON_DATA_COMPLETE: r_on_data_complete <= i_cfg_data[1:0];
                REG_ON_DATA_NACK:     r_on_data_nack     <= i_cfg_data[1:0];
                REG_ON_ADDRESS_NACK:  r_on_address_nack  <= i_cfg_data[1:0];
                REG_ON_COLLISION:     r_on_collision     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Phase logic. Each path raises at most one of the issue, stop or flush
    // requests; they are applied at the end so that an address issue after
    // a follow-up overrides the state left by the path that chose it.
    always_comb begin
        logic       do_issue;
        logic       issue_rd;
        logic       do_stop;
        logic       do_flush;
        logic [1:0] follow_sel;
        logic       do_follow;
        logic       do_send;
        logic [7:0] len_load;
        logic [7:0] left;
        logic       last;

        do_issue   = 1'b0;
        issue_rd   = 1'b0;
        do_stop    = 1'b0;
        do_flush   = 1'b0;
        follow_sel = FOLLOW_STOP;
        do_follow  = 1'b0;
        do_send    = 1'b0;
        last       = 1'b0;

        // Transfer length limited to one up to the longest transfer.
        len_load = (r_transfer_length == 8'd0) ? 8'd1 : r_transfer_length;
        if (len_load > LEN_MAX) begin
            len_load = LEN_MAX;
        end
        left = r_bytes_left;

        n_phase            = r_phase;
        n_bytes_left       = r_bytes_left;
        n_watch_addr       = r_watch_addr;
        n_busy             = r_busy;
        n_error            = r_error;
        n_on_data_complete = r_on_data_complete;
        n_on_data_nack     = r_on_data_nack;
        n_on_address_nack  = r_on_address_nack;
        n_on_collision     = r_on_collision;
        n_out              = '0;
        n_out.accepted     = 1'b1;

        if (r_in.action == ACT_START_WRITE || r_in.action == ACT_START_READ) begin
            if (r_busy) begin
                n_out.accepted = 1'b0;
            end else begin
                n_busy   = 1'b1;
                n_error  = 1'b0;
                do_issue = 1'b1;
                issue_rd = (r_in.action == ACT_START_READ);
            end
        end else if (r_in.action == ACT_OPEN) begin
            n_on_data_complete = FOLLOW_STOP;
            n_on_data_nack     = FOLLOW_STOP;
            n_on_address_nack  = FOLLOW_STOP;
            n_on_collision     = FOLLOW_STOP;
            n_watch_addr       = 1'b0;
            n_error            = 1'b0;
            n_bytes_left       = 8'd0;
            do_flush           = 1'b1;
        end else if (r_in.bus_error) begin
            n_error  = 1'b1;
            do_flush = 1'b1;
        end else if (r_in.arbitration_lost) begin
            n_error = 1'b1;
            if (r_on_collision == FOLLOW_RESTART_RD) begin
                do_issue = 1'b1;
                issue_rd = 1'b1;
            end else if (r_on_collision == FOLLOW_RESTART_WR) begin
                do_issue = 1'b1;
            end else begin
                do_flush = 1'b1;
            end
        end else if (r_watch_addr && r_in.nack_seen) begin
            n_error      = 1'b1;
            n_watch_addr = 1'b0;
            do_follow    = 1'b1;
            follow_sel   = r_on_address_nack;
        end else begin
            unique case (r_phase)
                PH_TX: begin
                    if (r_in.nack_seen) begin
                        do_follow  = 1'b1;
                        follow_sel = r_on_data_nack;
                    end else begin
                        do_send = 1'b1;
                    end
                end
                PH_TX_EMPTY: begin
                    if (r_in.nack_seen) begin
                        do_follow  = 1'b1;
                        follow_sel = r_on_data_nack;
                    end else begin
                        n_out.buffer_done = 1'b1;
                        if (r_on_data_complete == FOLLOW_CONTINUE) begin
                            // Reload the count and carry on writing at once.
                            left    = len_load;
                            do_send = 1'b1;
                        end else begin
                            do_follow  = 1'b1;
                            follow_sel = r_on_data_complete;
                        end
                    end
                end
                PH_RX: begin
                    last               = (r_bytes_left <= 8'd1);
                    n_watch_addr       = 1'b0;
                    n_out.ack_action   = last ? ACK_NACK : ACK_SET;
                    n_out.rx_valid     = 1'b1;
                    n_out.rx_data      = r_in.received_byte;
                    n_bytes_left       = (r_bytes_left != 8'd0) ? r_bytes_left - 8'd1
                                                                 : 8'd0;
                    if (!last) begin
                        n_out.bus_command = CMD_RECV;
                        n_phase           = PH_RX;
                    end else begin
                        n_out.buffer_done = 1'b1;
                        if (r_on_data_complete == FOLLOW_RESTART_RD ||
                            r_on_data_complete == FOLLOW_RESTART_WR) begin
                            n_phase = PH_RESTART;
                        end else begin
                            do_stop = 1'b1;
                        end
                    end
                end
                PH_RESTART: begin
                    // A restart after a read is always another read.
                    do_issue = 1'b1;
                    issue_rd = 1'b1;
                end
                PH_RESET: begin
                    do_flush = 1'b1;
                end
                default: begin
                    n_busy  = 1'b0;
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (do_follow) begin
            if (follow_sel == FOLLOW_RESTART_RD) begin
                do_issue = 1'b1;
                issue_rd = 1'b1;
            end else if (follow_sel == FOLLOW_RESTART_WR) begin
                do_issue = 1'b1;
            end else begin
                do_stop = 1'b1;
            end
        end

        if (do_send) begin
            n_watch_addr     = 1'b0;
            n_out.data_valid = 1'b1;
            n_out.data_byte  = r_in.next_tx_byte;
            n_bytes_left     = (left != 8'd0) ? left - 8'd1 : 8'd0;
            n_phase          = (n_bytes_left != 8'd0) ? PH_TX : PH_TX_EMPTY;
        end

        if (do_issue) begin
            n_out.addr_valid = 1'b1;
            n_out.addr_byte  = {r_target_address, issue_rd};
            n_watch_addr     = 1'b1;
            n_bytes_left     = len_load;
            n_phase          = issue_rd ? PH_RX : PH_TX;
        end

        if (do_stop) begin
            n_out.bus_command = CMD_STOP;
            n_busy            = 1'b0;
            n_phase           = PH_IDLE;
        end

        if (do_flush) begin
            n_out.bus_command = CMD_FLUSH;
            n_busy            = 1'b0;
            n_phase           = PH_RESET;
        end

        n_out.busy_res = n_busy;
        n_out.failed   = n_error;
    end

endmodule

`default_nettype wire

@@ tb/tb_i2c_master_transaction_sequencer_unit.sv @@
// Self-checking testbench for the I2C master transaction sequencer: a directed
// table followed by randomised transfers, results checked against a model or
// typed rows. Depends on i2cms_pkg and i2c_master_transaction_sequencer_unit.
`timescale 1ns / 100ps

module tb_i2c_master_transaction_sequencer_unit;
    import i2cms_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 38;

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input has a known value
    // from time zero.
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    i2c_master_transaction_sequencer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Sequencer model. It holds its own copy of the registers and of the
    // transfer state, and is stepped once for every transaction that the
    // block accepts on its input.
    // ------------------------------------------------------------------
    logic [6:0] cfg_target;
    logic [7:0] cfg_length;
    logic [1:0] cfg_on_complete;
    logic [1:0] cfg_on_data_nack;
    logic [1:0] cfg_on_addr_nack;
    logic [1:0] cfg_on_collision;

    t_phase     st_phase;
    logic [7:0] st_left;
    logic       st_watch_addr;
    logic       st_busy;
    logic       st_error;

    t_result    cmd_out;       // commands worked out for the current step
    t_result    pending_cmds[$];

    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    int reg_writes = 0;
    int refused_starts = 0;
    int bytes_received = 0;
    int buffers_done = 0;

    bit calm = 1'b0;           // no idling on either side while set
    bit hold_wanted = 1'b0;    // asks the receiver for its long hold-off

    task automatic reset_model();
        cfg_target       = '0;
        cfg_length       = 8'd1;
        cfg_on_complete  = FOLLOW_STOP;
        cfg_on_data_nack = FOLLOW_STOP;
        cfg_on_addr_nack = FOLLOW_STOP;
        cfg_on_collision = FOLLOW_STOP;
        st_phase         = PH_RESET;
        st_left          = '0;
        st_watch_addr    = 1'b0;
        st_busy          = 1'b0;
        st_error         = 1'b0;
    endtask

    // Byte count for a fresh address: zero counts as one, and the count never
    // exceeds the longest transfer.
    function automatic logic [7:0] clamped_length();
        logic [7:0] n;
        n = (cfg_length == 8'd0) ? 8'd1 : cfg_length;
        if (n > LEN_MAX) n = LEN_MAX;
        return n;
    endfunction

    task automatic issue_address(input bit rd);
        cmd_out.addr_valid = 1'b1;
        cmd_out.addr_byte  = {cfg_target, rd};
        st_watch_addr      = 1'b1;
        st_left            = clamped_length();
        st_phase           = rd ? PH_RX : PH_TX;
    endtask

    task automatic bus_stop();
        cmd_out.bus_command = CMD_STOP;
        st_busy  = 1'b0;
        st_phase = PH_IDLE;
    endtask

    task automatic bus_flush();
        cmd_out.bus_command = CMD_FLUSH;
        st_busy  = 1'b0;
        st_phase = PH_RESET;
    endtask

    // Follow-up after completion or a NACK; continue falls back to a stop.
    task automatic run_follow_up(input logic [1:0] sel);
        if (sel == FOLLOW_RESTART_RD) issue_address(1'b1);
        else if (sel == FOLLOW_RESTART_WR) issue_address(1'b0);
        else bus_stop();
    endtask

    task automatic send_data(input logic [7:0] b);
        st_watch_addr      = 1'b0;
        cmd_out.data_valid = 1'b1;
        cmd_out.data_byte  = b;
        if (st_left != 0) st_left--;
        st_phase = (st_left != 0) ? PH_TX : PH_TX_EMPTY;
    endtask

    task automatic predict_commands(input t_item it);
        bit last;
        cmd_out = '0;
        cmd_out.accepted = 1'b1;
        if (it.action == ACT_START_WRITE || it.action == ACT_START_READ) begin
            // A start while busy is refused and changes nothing.
            if (st_busy) begin
                cmd_out.accepted = 1'b0;
            end else begin
                st_busy  = 1'b1;
                st_error = 1'b0;
                issue_address(it.action == ACT_START_READ);
            end
        end else if (it.action == ACT_OPEN) begin
            // Open clears the follow-up registers but keeps address and length.
            cfg_on_complete  = FOLLOW_STOP;
            cfg_on_data_nack = FOLLOW_STOP;
            cfg_on_addr_nack = FOLLOW_STOP;
            cfg_on_collision = FOLLOW_STOP;
            st_watch_addr    = 1'b0;
            st_error         = 1'b0;
            st_left          = '0;
            bus_flush();
        end else if (it.bus_error) begin
            st_error = 1'b1;
            bus_flush();
        end else if (it.arbitration_lost) begin
            st_error = 1'b1;
            if (cfg_on_collision == FOLLOW_RESTART_RD) issue_address(1'b1);
            else if (cfg_on_collision == FOLLOW_RESTART_WR) issue_address(1'b0);
            else bus_flush();
        end else if (st_watch_addr && it.nack_seen) begin
            st_error      = 1'b1;
            st_watch_addr = 1'b0;
            run_follow_up(cfg_on_addr_nack);
        end else begin
            case (st_phase)
                PH_TX: begin
                    if (it.nack_seen) run_follow_up(cfg_on_data_nack);
                    else send_data(it.next_tx_byte);
                end
                PH_TX_EMPTY: begin
                    if (it.nack_seen) begin
                        run_follow_up(cfg_on_data_nack);
                    end else begin
                        cmd_out.buffer_done = 1'b1;
                        // Continue reloads the count and sends straight away.
                        if (cfg_on_complete == FOLLOW_CONTINUE) begin
                            st_left = clamped_length();
                            send_data(it.next_tx_byte);
                        end else begin
                            run_follow_up(cfg_on_complete);
                        end
                    end
                end
                PH_RX: begin
                    last = (st_left <= 8'd1);
                    st_watch_addr      = 1'b0;
                    cmd_out.ack_action = last ? ACK_NACK : ACK_SET;
                    cmd_out.rx_valid   = 1'b1;
                    cmd_out.rx_data    = it.received_byte;
                    if (st_left != 0) st_left--;
                    if (!last) begin
                        cmd_out.bus_command = CMD_RECV;
                        st_phase = PH_RX;
                    end else begin
                        cmd_out.buffer_done = 1'b1;
                        // Either restart code restarts as a read after a read.
                        if (cfg_on_complete == FOLLOW_RESTART_RD ||
                            cfg_on_complete == FOLLOW_RESTART_WR) begin
                            st_phase = PH_RESTART;
                        end else begin
                            bus_stop();
                        end
                    end
                end
                PH_RESTART: issue_address(1'b1);
                PH_RESET:   bus_flush();
                default: begin
                    st_busy  = 1'b0;
                    st_phase = PH_IDLE;
                end
            endcase
        end
        cmd_out.busy_res = st_busy;
        cmd_out.failed   = st_error;
    endtask

    // ------------------------------------------------------------------
    // Drivers. Everything is driven with nonblocking assignments straight
    // after a rising edge, and handshakes are judged on the values that
    // held just before that edge.
    // ------------------------------------------------------------------
    task automatic set_register(input logic [2:0] idx, input logic [7:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            REG_TARGET_ADDRESS:   cfg_target       = val[6:0];
            REG_TRANSFER_LENGTH:  cfg_length       = val;
            REG_ON_DATA_COMPLETE: cfg_on_complete  = val[1:0];
            REG_ON_DATA_NACK:     cfg_on_data_nack = val[1:0];
            REG_ON_ADDRESS_NACK:  cfg_on_addr_nack = val[1:0];
            REG_ON_COLLISION:     cfg_on_collision = val[1:0];
            default: ;
        endcase
        reg_writes++;
        // The valid is left high; the caller drops it after its last write.
    endtask

    // Offers one transaction, perhaps after a random gap, and records what
    // should come back once the block has taken it.
    task automatic offer_item(input t_item it, input bit typed, input t_result want);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= {5'b0, it.next_tx_byte, it.received_byte,
                          it.bus_error, it.arbitration_lost, it.nack_seen};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        predict_commands(it);
        pending_cmds.push_back(typed ? want : cmd_out);
        items_sent++;
    endtask

    // Lets every outstanding result arrive, then idles so that the block is
    // quiet before the registers change.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checking and the receiver's back-pressure.
    // ------------------------------------------------------------------
    function automatic string field_diffs(input t_result w, input t_result g);
        string s;
        s = "";
        if (w.accepted    !== g.accepted)    s = {s, " accepted"};
        if (w.addr_valid  !== g.addr_valid)  s = {s, " addr_valid"};
        if (w.addr_byte   !== g.addr_byte)   s = {s, " addr_byte"};
        if (w.data_valid  !== g.data_valid)  s = {s, " data_valid"};
        if (w.data_byte   !== g.data_byte)   s = {s, " data_byte"};
        if (w.ack_action  !== g.ack_action)  s = {s, " ack_action"};
        if (w.bus_command !== g.bus_command) s = {s, " bus_command"};
        if (w.rx_valid    !== g.rx_valid)    s = {s, " rx_valid"};
        if (w.rx_data     !== g.rx_data)     s = {s, " rx_data"};
        if (w.busy_res    !== g.busy_res)    s = {s, " busy_res"};
        if (w.failed      !== g.failed)      s = {s, " failed"};
        if (w.buffer_done !== g.buffer_done) s = {s, " buffer_done"};
        return s;
    endfunction

    function automatic string show(input t_result r);
        return {$sformatf("acc=%b av=%b ab=%h dv=%b db=%h ack=%0d cmd=%0d ",
                          r.accepted, r.addr_valid, r.addr_byte, r.data_valid,
                          r.data_byte, r.ack_action, r.bus_command),
                $sformatf("rv=%b rd=%h busy=%b fail=%b done=%b",
                          r.rx_valid, r.rx_data, r.busy_res, r.failed,
                          r.buffer_done)};
    endfunction

    initial begin : result_monitor
        t_result got;
        t_result want;
        string   diff;
        int      hold_left;
        bit      hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.accepted    = m_axis_tdata[0];
                got.addr_valid  = m_axis_tdata[1];
                got.addr_byte   = m_axis_tdata[9:2];
                got.data_valid  = m_axis_tdata[10];
                got.data_byte   = m_axis_tdata[18:11];
                got.ack_action  = m_axis_tdata[20:19];
                got.bus_command = m_axis_tdata[22:21];
                got.rx_valid    = m_axis_tdata[23];
                got.rx_data     = m_axis_tdata[31:24];
                got.busy_res    = m_axis_tdata[32];
                got.failed      = m_axis_tdata[33];
                got.buffer_done = m_axis_tdata[34];
                results_seen++;
                if (!got.accepted) refused_starts++;
                if (got.rx_valid) bytes_received++;
                if (got.buffer_done) buffers_done++;
                if (pending_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: %s", $realtime, show(got));
                end else begin
                    want = pending_cmds.pop_front();
                    diff = field_diffs(want, got);
                    if (diff != "") begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] result %0d differs in%s", $realtime,
                                     results_seen, diff);
                            $display("    expected %s", show(want));
                            $display("    actual   %s", show(got));
                        end
                    end
                end
            end
            // One long hold-off, counted here, fills the block up while the
            // sender keeps offering; otherwise the receiver stalls at random.
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_wanted && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 199;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, pending_cmds.size());
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Directed table. A row either writes a register or offers one
    // transaction; rows marked typed carry their result written out by hand.
    // ------------------------------------------------------------------
    typedef struct {
        bit         is_reg;
        logic [2:0] idx;
        logic [7:0] val;
        t_item      it;
        bit         typed;
        t_result    want;
    } t_row;

    function automatic t_row reg_row(input logic [2:0] idx, input logic [7:0] val);
        t_row r;
        r = '{default: '0};
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic t_row item_row(input t_action a, input bit nack, input bit arb,
                                      input bit berr, input logic [7:0] rx,
                                      input logic [7:0] tx);
        t_row r;
        r = '{default: '0};
        r.it.action           = a;
        r.it.nack_seen        = nack;
        r.it.arbitration_lost = arb;
        r.it.bus_error        = berr;
        r.it.received_byte    = rx;
        r.it.next_tx_byte     = tx;
        return r;
    endfunction

    function automatic t_row with_result(input t_row r, input bit acc, input bit av,
                                         input logic [7:0] ab, input logic [1:0] cmd,
                                         input bit busy, input bit fail);
        t_row o;
        o = r;
        o.typed = 1'b1;
        o.want  = '0;
        o.want.accepted    = acc;
        o.want.addr_valid  = av;
        o.want.addr_byte   = ab;
        o.want.bus_command = cmd;
        o.want.busy_res    = busy;
        o.want.failed      = fail;
        return o;
    endfunction

    initial begin : stimulus
        t_row    script[$];
        t_item   it;
        t_result none;
        int      burst_no;
        int      burst_len;
        int      k;
        int      pick;
        logic [7:0] len;

        reset_model();
        none = '0;

        // Just after reset the sequencer sits in its reset phase and flushes.
        script.push_back(with_result(item_row(ACT_EVENT, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00),
                                     1'b1, 1'b0, 8'h00, CMD_FLUSH, 1'b0, 1'b0));
        script.push_back(reg_row(REG_TARGET_ADDRESS, 8'd127));
        script.push_back(reg_row(REG_TRANSFER_LENGTH, 8'd2));
        // Flags on a start are ignored; the write address is the top value.
        script.push_back(with_result(item_row(ACT_START_WRITE, 1'b1, 1'b1, 1'b1,
                                              8'hFF, 8'hFF),
                                     1'b1, 1'b1, 8'hFE, CMD_NONE, 1'b1, 1'b0));
        // A start while busy is refused.
        script.push_back(with_result(item_row(ACT_START_READ, 1'b0, 1'b0, 1'b0,
                                              8'h00, 8'h00),
                                     1'b0, 1'b0, 8'h00, CMD_NONE, 1'b1, 1'b0));
        // Address NACK with the stop follow-up; the error flag is raised.
        script.push_back(with_result(item_row(ACT_EVENT, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00),
                                     1'b1, 1'b0, 8'h00, CMD_STOP, 1'b0, 1'b1));
        // A new start clears the error flag.
        script.push_back(with_result(item_row(ACT_START_READ, 1'b0, 1'b0, 1'b0,
                                              8'h00, 8'h00),
                                     1'b1, 1'b1, 8'hFF, CMD_NONE, 1'b1, 1'b0));
        script.push_back(item_row(ACT_EVENT, 1'b0, 1'b0, 1'b0, 8'hFF, 8'h00));
        script.push_back(item_row(ACT_EVENT, 1'b0, 1'b0, 1'b0, 8'h00, 8'hFF));
        // Write with continue on completion: the count is reloaded each time.
        script.push_back(reg_row(REG_TARGET_ADDRESS, 8'd0));
        script.push_back(reg_row(REG_TRANSFER_LENGTH, 8'd1));
        script.push_back(reg_row(REG_ON_DATA_COMPLETE, 8'(FOLLOW_CONTINUE)));
        script.push_back(item_row(ACT_START_WRITE, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
        script.push_back(item_row(ACT_EVENT, 1'b0, 1'b0, 1'b0, 8'h00, 8'hA5));
        script.push_back(item_row(ACT_EVENT, 1'b0, 1'b0, 1'b0, 8'h00, 8'h5A));
        script.push_back(item_row(ACT_EVENT, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
        // Restart follow-ups, collision and bus error.
        script.push_back(reg_row(REG_TARGET_ADDRESS, 8'h55));
        script.push_back(reg_row(REG_ON_DATA_COMPLETE, 8'(FOLLOW_RESTART_RD)));
        script.push_back(reg_row(REG_ON_DATA_NACK, 8'(FOLLOW_RESTART_RD)));
        script.push_back(reg_row(REG_ON_ADDRESS_NACK, 8'(FOLLOW_RESTART_WR)));
        script.push_back(reg_row(REG_ON_COLLISION, 8'(FOLLOW_RESTART_WR)));
        script.push_back(item_row(ACT_START_WRITE, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
        script.push_back(item_row(ACT_EVENT, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00));
        // Bus error outranks the other event flags and flushes.
        script.push_back(with_result(item_row(ACT_EVENT, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00),
                                     1'b1, 1'b0, 8'h00, CMD_FLUSH, 1'b0, 1'b1));
        script.push_back(with_result(item_row(ACT_EVENT, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00),
                                     1'b1, 1'b0, 8'h00, CMD_FLUSH, 1'b0, 1'b1));
        script.push_back(item_row(ACT_START_READ, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
        script.push_back(item_row(ACT_EVENT, 1'b0, 1'b0, 1'b0, 8'h3C, 8'h00));
        script.push_back(item_row(ACT_EVENT, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
        script.push_back(item_row(ACT_EVENT, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
        script.push_back(item_row(ACT_EVENT, 1'b0, 1'b0, 1'b0, 8'h00, 8'h81));
        script.push_back(item_row(ACT_EVENT, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
        // Open mid-transfer: flush, flags cleared, follow-ups back to stop.
        script.push_back(with_result(item_row(ACT_OPEN, 1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF),
                                     1'b1, 1'b0, 8'h00, CMD_FLUSH, 1'b0, 1'b0));
        script.push_back(with_result(item_row(ACT_START_WRITE, 1'b0, 1'b0, 1'b0,
                                              8'h00, 8'h00),
                                     1'b1, 1'b1, 8'hAA, CMD_NONE, 1'b1, 1'b0));
        script.push_back(with_result(item_row(ACT_EVENT, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00),
                                     1'b1, 1'b0, 8'h00, CMD_STOP, 1'b0, 1'b1));
        // An event while idle does nothing; the error flag survives the stop.
        script.push_back(with_result(item_row(ACT_EVENT, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00),
                                     1'b1, 1'b0, 8'h00, CMD_NONE, 1'b0, 1'b1));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_reg) begin
                if (i == 0 || !script[i - 1].is_reg) drain_results();
                set_register(script[i].idx, script[i].val);
            end else begin
                if (i_cfg_valid) i_cfg_valid <= 1'b0;
                offer_item(script[i].it, script[i].typed, script[i].want);
            end
        end

        // Random part: each burst starts from fresh register settings, and
        // the transactions follow the model's state so that most of them
        // make well-formed transfers, with noise mixed in.
        burst_no = 0;
        while (items_sent < script.size() + RANDOM_ITEMS) begin
            drain_results();
            if (burst_no == 0) len = 8'd255;
            else if (burst_no == 1) len = 8'd1;
            else begin
                pick = $urandom_range(99);
                if (pick < 70) len = 8'($urandom_range(1, 4));
                else if (pick < 95) len = 8'($urandom_range(5, 16));
                else len = 8'd255;
            end
            set_register(REG_TARGET_ADDRESS,
                         (burst_no == 0) ? 8'd127 :
                         (burst_no == 1) ? 8'd0 : 8'($urandom_range(0, 127)));
            set_register(REG_TRANSFER_LENGTH, len);
            set_register(REG_ON_DATA_COMPLETE, 8'($urandom_range(0, 3)));
            set_register(REG_ON_DATA_NACK, 8'($urandom_range(0, 3)));
            set_register(REG_ON_ADDRESS_NACK, 8'($urandom_range(0, 3)));
            set_register(REG_ON_COLLISION, 8'($urandom_range(0, 3)));
            i_cfg_valid <= 1'b0;

            calm = (burst_no >= 10 && burst_no <= 13);
            if (burst_no == 5) hold_wanted = 1'b1;
            burst_len = $urandom_range(40, 120);

            for (k = 0; k < burst_len; k++) begin
                it.received_byte    = 8'($urandom);
                it.next_tx_byte     = 8'($urandom);
                it.nack_seen        = 1'($urandom_range(1));
                it.arbitration_lost = 1'($urandom_range(1));
                it.bus_error        = 1'($urandom_range(1));
                pick = $urandom_range(99);
                if (!st_busy) begin
                    if (pick < 80) it.action = t_action'($urandom_range(0, 1));
                    else if (pick < 95) it.action = ACT_EVENT;
                    else it.action = ACT_OPEN;
                end else begin
                    if (pick < 3) it.action = ACT_OPEN;
                    else if (pick < 8) it.action = t_action'($urandom_range(0, 1));
                    else it.action = ACT_EVENT;
                end
                // Events mostly carry clean flags so that transfers run on.
                if (it.action == ACT_EVENT) begin
                    it.bus_error        = ($urandom_range(99) < 2);
                    it.arbitration_lost = ($urandom_range(99) < 3);
                    it.nack_seen        = ($urandom_range(99) < 12);
                end
                offer_item(it, 1'b0, none);
            end
            burst_no++;
        end

        // Let the last results through, then idle before the final check.
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_cmds.size() != 0) mismatches++;

        $display("run covered %0d transactions in %0d bursts, %0d register writes",
                 items_sent, burst_no, reg_writes);
        $display("%0d results checked: %0d refused starts, %0d bytes received, %0d buffers done",
                 results_seen, refused_starts, bytes_received, buffers_done);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
